@@ hw/rtl/mfsp_pkg.sv @@
// Shared types, constants and helpers for the MIDI file stream parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mfsp_pkg;

  // Default for the longest sysex payload forwarded per event
  localparam int unsigned MAX_DATA_DEF = 128;

  // Time step arithmetic: delta (32) times tempo (24), divisor tpb (16) times 1000
  localparam int unsigned DELTA_W = 32;
  localparam int unsigned TEMPO_W = 24;
  localparam int unsigned TPB_W   = 16;
  localparam int unsigned PROD_W  = DELTA_W + TEMPO_W;
  localparam int unsigned DEN_W   = TPB_W + 10;
  localparam int unsigned CNT_W   = $clog2(PROD_W);
  localparam int unsigned TIME_W  = 32;

  localparam logic [9:0]         MS_PER_S  = 10'd1000;
  localparam logic [TEMPO_W-1:0] TEMPO_RST = 24'd500000;

  // Header identifiers and fixed header length
  localparam logic [31:0] ID_MTHD     = 32'h4D546864;
  localparam logic [31:0] ID_MTRK     = 32'h4D54726B;
  localparam logic [31:0] MTHD_LEN    = 32'd6;

  // Header byte positions
  localparam logic [3:0] HB_ID_END    = 4'd3;
  localparam logic [3:0] HB_LEN_END   = 4'd7;
  localparam logic [3:0] HB_NTRK_END  = 4'd11;
  localparam logic [3:0] HB_DIV_END   = 4'd13;

  // Status byte codes
  localparam logic [7:0] SB_META      = 8'hFF;
  localparam logic [7:0] SB_SYSEX     = 8'hF0;
  localparam logic [7:0] SB_SYSEX_END = 8'hF7;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] CLASS_MASK   = 8'hE0;
  localparam logic [7:0] CLASS_ONE    = 8'hC0;

  typedef enum logic [1:0] {
    KIND_MIDI       = 2'd0,
    KIND_BAD_FILE   = 2'd1,
    KIND_BAD_TRACK  = 2'd2,
    KIND_DONE       = 2'd3
  } kind_t;

  // Parser phase, one-hot
  typedef enum logic [12:0] {
    PH_FILE_HDR     = 13'h0001,
    PH_FILE_HDR_BAD = 13'h0002,
    PH_TRK_HDR      = 13'h0004,
    PH_TRK_HDR_BAD  = 13'h0008,
    PH_DELTA        = 13'h0010,
    PH_STATUS       = 13'h0020,
    PH_META_TYPE    = 13'h0040,
    PH_META_LEN     = 13'h0080,
    PH_META_DATA    = 13'h0100,
    PH_SYSEX        = 13'h0200,
    PH_MIDI_DATA    = 13'h0400,
    PH_FINISH_PEND  = 13'h0800,
    PH_HALT         = 13'h1000
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       flush;
  } res_t;

  typedef struct packed {
    logic [1:0]      n;
    res_t [1:0]      r;
  } res_set_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_byte;
    logic mul_go;
    logic div_go;
    logic ms_load;
    logic commit;
    logic out_sel;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic       need_adv;
    logic       div_done;
    logic [1:0] res_n;
    logic [1:0] buf_n;
  } dp_sts_t;

  // Append one result unless both slots are taken
  function automatic res_set_t put_res(res_set_t s, kind_t k, logic [7:0] d, logic fl);
    res_set_t o;
    o = s;
    if (s.n < 2'd2) begin
      o.r[s.n[0]].kind  = k;
      o.r[s.n[0]].data  = d;
      o.r[s.n[0]].flush = fl;
      o.n               = s.n + 2'd1;
    end
    return o;
  endfunction

  // Data bytes that follow a channel status
  function automatic logic [1:0] data_count(logic [7:0] s);
    return ((s & CLASS_MASK) == CLASS_ONE) ? 2'd1 : 2'd2;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/midi_file_stream_parser_unit.sv @@
// Top level of the MIDI file stream parser: controller plus datapath.
// Depends on mfsp_pkg, mfsp_ctrl and mfsp_dp.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_file_byte
//   out     | output    | out_valid/out_stall| out_kind, out_midi_byte, out_flush_before,
//           |           |                    | out_time_ms, out_last
//
// A byte that causes no time step is loaded, evaluated and committed, then its results are delivered.
// A byte that advances play time (status byte, end of a meta event) also runs the time
// product and the bit-serial 56-bit divider before commit.
// Reset (rst_n low, synchronous) returns the parser to expecting the file header.
// While results are pending the input is stalled; a stalled result holds steady.
`default_nettype none

module midi_file_stream_parser_unit #(
  parameter int unsigned MAX_DATA = mfsp_pkg::MAX_DATA_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire [7:0]   in_file_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_midi_byte,
  output logic        out_flush_before,
  output logic [31:0] out_time_ms,
  output logic        out_last
);
  import mfsp_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  mfsp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mfsp_dp #(
    .MAX_DATA (MAX_DATA)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .byte_i      (in_file_byte),
    .kind_o      (out_kind),
    .midi_byte_o (out_midi_byte),
    .flush_o     (out_flush_before),
    .time_o      (out_time_ms),
    .last_o      (out_last)
  );

endmodule

`default_nettype wire

@@ hw/rtl/mfsp_div.sv @@
// Restoring divider, one quotient bit per cycle, for the play-time step.
// Depends on mfsp_pkg for operand widths.
`default_nettype none

module mfsp_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start_i,
  input  wire [mfsp_pkg::PROD_W-1:0]   dividend_i,
  input  wire [mfsp_pkg::DEN_W-1:0]    divisor_i,
  output logic                         done_o,
  output logic [mfsp_pkg::TIME_W-1:0]  quot_o
);
  import mfsp_pkg::*;

  logic [PROD_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  div_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [DEN_W+1:0]  diff;

  // One trial subtract per cycle
  always_comb begin
    diff     = {1'b0, rem_r, q_r[PROD_W-1]} - {2'b00, div_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = done_r;
    if (start_i) begin
      q_nxt    = dividend_i;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
      done_nxt = 1'b0;
    end else if (run_r) begin
      if (!diff[DEN_W+1]) begin
        rem_nxt = diff[DEN_W-1:0];
        q_nxt   = {q_r[PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DEN_W-2:0], q_r[PROD_W-1]};
        q_nxt   = {q_r[PROD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(PROD_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Hold operands
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start_i) begin
      div_r <= divisor_i;
    end
  end

  assign done_o = done_r;
  assign quot_o = q_r[TIME_W-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/mfsp_dp.sv @@
// Parser datapath: file state registers, per-byte step logic, time product and divider.
// Depends on mfsp_pkg and mfsp_div.
`default_nettype none

module mfsp_dp #(
  parameter int unsigned MAX_DATA = mfsp_pkg::MAX_DATA_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  mfsp_pkg::ctrl_cmd_t          cmd_i,
  output mfsp_pkg::dp_sts_t            sts_o,
  input  wire [7:0]                    byte_i,
  output logic [1:0]                   kind_o,
  output logic [7:0]                   midi_byte_o,
  output logic                         flush_o,
  output logic [mfsp_pkg::TIME_W-1:0]  time_o,
  output logic                         last_o
);
  import mfsp_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_DATA + 1);

  // Parser state
  phase_t            phase_r, phase_nxt;
  logic [3:0]        bcnt_r, bcnt_nxt;
  logic [31:0]       shift_r, shift_nxt;
  logic [15:0]       tcount_r, tcount_nxt;
  logic [15:0]       tdone_r, tdone_nxt;
  logic [TPB_W-1:0]  tpb_r, tpb_nxt;
  logic [31:0]       tlen_r, tlen_nxt;
  logic [31:0]       tpos_r, tpos_nxt;
  logic [DELTA_W-1:0] delta_r, delta_nxt;
  logic [7:0]        rstat_r, rstat_nxt;
  logic [7:0]        mtype_r, mtype_nxt;
  logic [31:0]       drem_r, drem_nxt;
  logic [IDX_W-1:0]  didx_r, didx_nxt;
  logic [2:0][7:0]   tb_r, tb_nxt;
  logic [TEMPO_W-1:0] tempo_r, tempo_nxt;
  logic [TIME_W-1:0] ntime_r, ntime_nxt;
  logic [TIME_W-1:0] etime_r, etime_nxt;

  // Work registers
  logic [7:0]        byte_r;
  logic [PROD_W-1:0] prod_r;
  logic [DEN_W-1:0]  den_r;
  logic [TIME_W-1:0] ms_r;
  res_set_t          res_r;

  res_set_t          rs;
  logic              adv, end_ev, fin, flush_now;
  logic [TIME_W-1:0] tn;
  logic [31:0]       sw;
  logic [3:0]        k;
  logic              div_done;
  logic [TIME_W-1:0] quot;

  // Step the parser over the held byte
  always_comb begin
    phase_nxt  = phase_r;
    bcnt_nxt   = bcnt_r;
    shift_nxt  = shift_r;
    tcount_nxt = tcount_r;
    tdone_nxt  = tdone_r;
    tpb_nxt    = tpb_r;
    tlen_nxt   = tlen_r;
    tpos_nxt   = tpos_r;
    delta_nxt  = delta_r;
    rstat_nxt  = rstat_r;
    mtype_nxt  = mtype_r;
    drem_nxt   = drem_r;
    didx_nxt   = didx_r;
    tb_nxt     = tb_r;
    tempo_nxt  = tempo_r;
    ntime_nxt  = ntime_r;
    etime_nxt  = etime_r;
    rs         = '0;
    adv        = 1'b0;
    end_ev     = 1'b0;
    fin        = 1'b0;
    tn         = ntime_r + ms_r;
    flush_now  = (etime_r != tn);
    k          = bcnt_r;
    sw         = {shift_r[23:0], byte_r};

    unique case (phase_r)
      PH_FILE_HDR, PH_FILE_HDR_BAD: begin
        shift_nxt = sw;
        if (k == HB_ID_END && sw != ID_MTHD) begin
          phase_nxt = PH_FILE_HDR_BAD;
        end
        if (k == HB_LEN_END && sw != MTHD_LEN) begin
          phase_nxt = PH_FILE_HDR_BAD;
        end
        if (k == HB_NTRK_END) begin
          tcount_nxt = sw[15:0];
        end
        if (k == HB_DIV_END) begin
          tpb_nxt   = sw[TPB_W-1:0];
          tempo_nxt = TEMPO_RST;
          tdone_nxt = '0;
          if (phase_nxt == PH_FILE_HDR_BAD || sw[TPB_W-1:0] == '0) begin
            phase_nxt = PH_HALT;
            rs = put_res(rs, KIND_BAD_FILE, 8'h00, 1'b0);
          end else if (tcount_nxt == '0) begin
            fin = 1'b1;
          end else begin
            phase_nxt = PH_TRK_HDR;
            bcnt_nxt  = '0;
            shift_nxt = '0;
          end
        end else begin
          bcnt_nxt = k + 4'd1;
        end
      end
      PH_TRK_HDR, PH_TRK_HDR_BAD: begin
        shift_nxt = sw;
        if (k == HB_ID_END && sw != ID_MTRK) begin
          phase_nxt = PH_TRK_HDR_BAD;
        end
        if (k == HB_LEN_END) begin
          tlen_nxt = sw;
          if (phase_nxt == PH_TRK_HDR_BAD) begin
            phase_nxt = PH_HALT;
            rs = put_res(rs, KIND_BAD_TRACK, 8'h00, 1'b0);
          end else begin
            tpos_nxt = '0;
            end_ev   = 1'b1;
          end
        end else begin
          bcnt_nxt = k + 4'd1;
        end
      end
      PH_DELTA: begin
        tpos_nxt  = tpos_r + 32'd1;
        delta_nxt = {delta_r[DELTA_W-8:0], byte_r[6:0]};
        if (!byte_r[7]) begin
          phase_nxt = PH_STATUS;
        end
      end
      PH_STATUS: begin
        tpos_nxt = tpos_r + 32'd1;
        if (byte_r == SB_META) begin
          phase_nxt = PH_META_TYPE;
        end else if (byte_r == SB_SYSEX || byte_r == SB_SYSEX_END) begin
          didx_nxt  = '0;
          adv       = 1'b1;
          ntime_nxt = tn;
          etime_nxt = tn;
          rs        = put_res(rs, KIND_MIDI, byte_r, flush_now);
          phase_nxt = PH_SYSEX;
        end else if (byte_r[7]) begin
          rstat_nxt = byte_r;
          drem_nxt  = {30'd0, data_count(byte_r)};
          adv       = 1'b1;
          ntime_nxt = tn;
          etime_nxt = tn;
          rs        = put_res(rs, KIND_MIDI, byte_r, flush_now);
          phase_nxt = PH_MIDI_DATA;
        end else begin
          // Running status: replay the held status, then this data byte
          drem_nxt  = {30'd0, data_count(rstat_r) - 2'd1};
          adv       = 1'b1;
          ntime_nxt = tn;
          etime_nxt = tn;
          rs        = put_res(rs, KIND_MIDI, rstat_r, flush_now);
          rs        = put_res(rs, KIND_MIDI, byte_r, 1'b0);
          if (drem_nxt == '0) begin
            end_ev = 1'b1;
          end else begin
            phase_nxt = PH_MIDI_DATA;
          end
        end
      end
      PH_META_TYPE: begin
        tpos_nxt  = tpos_r + 32'd1;
        mtype_nxt = byte_r;
        drem_nxt  = '0;
        didx_nxt  = '0;
        tb_nxt    = '0;
        phase_nxt = PH_META_LEN;
      end
      PH_META_LEN, PH_META_DATA: begin
        tpos_nxt = tpos_r + 32'd1;
        if (phase_r == PH_META_LEN) begin
          drem_nxt = {drem_r[24:0], byte_r[6:0]};
          if (!byte_r[7]) begin
            if (drem_nxt != '0) begin
              phase_nxt = PH_META_DATA;
            end else begin
              end_ev = 1'b1;
            end
          end
        end else begin
          if (didx_r < IDX_W'(3)) begin
            tb_nxt[didx_r[1:0]] = byte_r;
            didx_nxt = didx_r + 1'b1;
          end
          drem_nxt = drem_r - 32'd1;
          if (drem_nxt == '0) begin
            end_ev = 1'b1;
          end
        end
        // Meta event complete: apply tempo, then advance time
        if (end_ev) begin
          if (mtype_r == META_TEMPO) begin
            tempo_nxt = {tb_nxt[0], tb_nxt[1], tb_nxt[2]};
          end
          adv       = 1'b1;
          ntime_nxt = tn;
        end
      end
      PH_SYSEX: begin
        tpos_nxt = tpos_r + 32'd1;
        if (didx_r < IDX_W'(MAX_DATA)) begin
          rs       = put_res(rs, KIND_MIDI, byte_r, 1'b0);
          didx_nxt = didx_r + 1'b1;
        end
        if (byte_r == SB_SYSEX_END || tpos_nxt >= tlen_r) begin
          end_ev = 1'b1;
        end
      end
      PH_MIDI_DATA: begin
        tpos_nxt = tpos_r + 32'd1;
        rs       = put_res(rs, KIND_MIDI, byte_r, 1'b0);
        if (drem_r != '0) begin
          drem_nxt = drem_r - 32'd1;
        end
        if (drem_nxt == '0) begin
          end_ev = 1'b1;
        end
      end
      PH_FINISH_PEND: begin
        fin = 1'b1;
      end
      PH_HALT: begin
        phase_nxt = PH_HALT;
      end
      default: begin
        phase_nxt = PH_HALT;
      end
    endcase

    // Close the event: next delta, next track, or end of file
    if (end_ev) begin
      if (tpos_nxt >= tlen_nxt) begin
        tdone_nxt = tdone_nxt + 16'd1;
        if (tdone_nxt >= tcount_nxt) begin
          fin = 1'b1;
        end else begin
          phase_nxt = PH_TRK_HDR;
          bcnt_nxt  = '0;
          shift_nxt = '0;
        end
      end else begin
        phase_nxt = PH_DELTA;
        delta_nxt = '0;
      end
    end

    // Report finish now if a slot is free, else on the next byte
    if (fin) begin
      if (rs.n < 2'd2) begin
        phase_nxt = PH_HALT;
        rs = put_res(rs, KIND_DONE, 8'h00, 1'b0);
      end else begin
        phase_nxt = PH_FINISH_PEND;
      end
    end
  end

  // Commit parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FILE_HDR;
      bcnt_r   <= '0;
      shift_r  <= '0;
      tcount_r <= '0;
      tdone_r  <= '0;
      tpb_r    <= '0;
      tlen_r   <= '0;
      tpos_r   <= '0;
      delta_r  <= '0;
      rstat_r  <= '0;
      mtype_r  <= '0;
      drem_r   <= '0;
      didx_r   <= '0;
      tb_r     <= '0;
      tempo_r  <= TEMPO_RST;
      ntime_r  <= '0;
      etime_r  <= '0;
      res_r    <= '0;
    end else if (cmd_i.commit) begin
      phase_r  <= phase_nxt;
      bcnt_r   <= bcnt_nxt;
      shift_r  <= shift_nxt;
      tcount_r <= tcount_nxt;
      tdone_r  <= tdone_nxt;
      tpb_r    <= tpb_nxt;
      tlen_r   <= tlen_nxt;
      tpos_r   <= tpos_nxt;
      delta_r  <= delta_nxt;
      rstat_r  <= rstat_nxt;
      mtype_r  <= mtype_nxt;
      drem_r   <= drem_nxt;
      didx_r   <= didx_nxt;
      tb_r     <= tb_nxt;
      tempo_r  <= tempo_nxt;
      ntime_r  <= ntime_nxt;
      etime_r  <= etime_nxt;
      res_r    <= rs;
    end
  end

  // Hold the byte, the product, the divisor and the time step
  always_ff @(posedge clk) begin
    if (cmd_i.load_byte) begin
      byte_r <= byte_i;
      ms_r   <= '0;
    end else if (cmd_i.ms_load) begin
      ms_r   <= (den_r == '0) ? '0 : quot;
    end
    if (cmd_i.mul_go) begin
      prod_r <= PROD_W'(delta_r) * PROD_W'(tempo_nxt);
      den_r  <= DEN_W'(tpb_r) * DEN_W'(MS_PER_S);
    end
  end

  mfsp_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (cmd_i.div_go),
    .dividend_i (prod_r),
    .divisor_i  (den_r),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign sts_o.need_adv = adv;
  assign sts_o.div_done = div_done;
  assign sts_o.res_n    = rs.n;
  assign sts_o.buf_n    = res_r.n;

  // Present the selected buffered result
  assign kind_o      = res_r.r[cmd_i.out_sel].kind;
  assign midi_byte_o = res_r.r[cmd_i.out_sel].data;
  assign flush_o     = res_r.r[cmd_i.out_sel].flush;
  assign time_o      = ntime_r;
  assign last_o      = ({1'b0, cmd_i.out_sel} == (res_r.n - 2'd1));

endmodule

`default_nettype wire

@@ hw/rtl/mfsp_ctrl.sv @@
// Sequencer for the parser: take a byte, run the time step if needed, commit, drain results.
// Depends on mfsp_pkg for the command and status structs.
`default_nettype none

module mfsp_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  input  mfsp_pkg::dp_sts_t    sts_i,
  output mfsp_pkg::ctrl_cmd_t  cmd_o
);
  import mfsp_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'h01,
    ST_EVAL   = 7'h02,
    ST_DIVS   = 7'h04,
    ST_DIV    = 7'h08,
    ST_COMMIT = 7'h10,
    ST_OUT    = 7'h20,
    ST_SPARE  = 7'h40
  } ctrl_state_t;

  ctrl_state_t st_r, st_nxt;
  logic        sel_r, sel_nxt;

  // Advance the sequencer
  always_comb begin
    st_nxt  = st_r;
    sel_nxt = sel_r;
    cmd_o   = '0;
    cmd_o.out_sel = sel_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_byte = 1'b1;
          st_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts_i.need_adv) begin
          cmd_o.mul_go = 1'b1;
          st_nxt = ST_DIVS;
        end else begin
          st_nxt = ST_COMMIT;
        end
      end
      ST_DIVS: begin
        cmd_o.div_go = 1'b1;
        st_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.ms_load = 1'b1;
          st_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        sel_nxt = 1'b0;
        st_nxt  = (sts_i.res_n == 2'd0) ? ST_IDLE : ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          if ({1'b0, sel_r} == sts_i.buf_n - 2'd1) begin
            st_nxt = ST_IDLE;
          end else begin
            sel_nxt = sel_r + 1'b1;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      sel_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      sel_r <= sel_nxt;
    end
  end

  assign in_stall_o  = (st_r != ST_IDLE);
  assign out_valid_o = (st_r == ST_OUT);

`ifndef SYNTH
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_r))
    else $error("controller state not one-hot");
  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid_o && !in_stall_o))
    else $error("request taken while results pending");
  a_empty_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_COMMIT && sts_i.res_n == 2'd0) |=> st_r == ST_IDLE)
    else $error("empty commit did not return to idle");
  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT) |-> ({1'b0, sel_r} < sts_i.buf_n))
    else $error("result select beyond buffered count");
`endif

endmodule

`default_nettype wire
